// ----- rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Request and response types, opcodes and status codes shared by the
// first-fit heap allocator and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int SIZE_W = 11;
  localparam int OFF_W  = 10;
  localparam int FREE_W = 11;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  block_offset;
  } ffha_req_t;

  typedef struct packed {
    logic              status;
    logic [OFF_W-1:0]  payload_offset;
    logic [FREE_W-1:0] free_bytes;
  } ffha_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a fixed heap with headers held in a block RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate that is refused on the
// free-byte count goes straight to the response; otherwise the walk reads
// one header from the header store per header visited on the chain, and a
// free remainder that is split off takes one more header write. A release
// does one header read and one write back; a release refused on its offset
// goes straight to the response. The single read port of the header store
// sets the walk rate. A finished response sits in an output register, so
// the next request is taken while it waits. After reset the heap is one
// free block and no initialisation pass is needed.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = 1024,
  parameter int NODE_BYTES = 16,
  parameter int ROOT_BYTES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ffha_pkg::ffha_req_t in_req,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ffha_pkg::ffha_rsp_t      out_rsp
);

  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int EW = $clog2(HEAP_BYTES+1) + 1;

  logic          busy;
  logic          res_valid;
  ffha_rsp_t     res;
  logic          res_taken;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [EW-1:0] mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [EW-1:0] mem_wr_data;

  logic          out_valid_r, out_valid_nxt;
  ffha_rsp_t     out_rsp_r;

  ffha_ctrl #(
    .HEAP_BYTES (HEAP_BYTES),
    .NODE_BYTES (NODE_BYTES),
    .ROOT_BYTES (ROOT_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req         (in_req),
    .busy        (busy),
    .res_valid   (res_valid),
    .res         (res),
    .res_taken   (res_taken),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  ffha_hdr_mem #(
    .DEPTH (HEAP_BYTES),
    .WIDTH (EW)
  ) u_hdr_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign in_stall  = busy;
  assign res_taken = res_valid && (!out_valid_r || !out_stall);

  assign out_valid_nxt = res_taken || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_rsp_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

// ----- rtl/ffha_hdr_mem.sv -----
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_hdr_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: walks the header chain through the header store,
// updates headers by read-modify-write and keeps the free-byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl #(
  parameter int HEAP_BYTES = 1024,
  parameter int NODE_BYTES = 16,
  parameter int ROOT_BYTES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            req_valid,
  input  wire ffha_pkg::ffha_req_t             req,
  output logic                                 busy,
  output logic                                 res_valid,
  output ffha_pkg::ffha_rsp_t                  res,
  input  wire logic                            res_taken,
  output logic                                 mem_rd_en,
  output logic [$clog2(HEAP_BYTES)-1:0]        mem_rd_addr,
  input  wire logic [$clog2(HEAP_BYTES+1):0]   mem_rd_data,
  output logic                                 mem_wr_en,
  output logic [$clog2(HEAP_BYTES)-1:0]        mem_wr_addr,
  output logic [$clog2(HEAP_BYTES+1):0]        mem_wr_data
);

  import ffha_pkg::*;

  localparam int SZ_W = $clog2(HEAP_BYTES+1);
  localparam int AW   = $clog2(HEAP_BYTES);
  localparam int WA_W = $clog2(2*HEAP_BYTES+1);
  localparam int X_W  = WA_W + 12;

  localparam bit HAS_BLOCK = (ROOT_BYTES + NODE_BYTES <= HEAP_BYTES);

  localparam logic [X_W-1:0] NODE_X = X_W'(NODE_BYTES);
  localparam logic [X_W-1:0] HEAP_X = X_W'(HEAP_BYTES);
  localparam logic [X_W-1:0] ROOT_X = X_W'(ROOT_BYTES);
  localparam logic [X_W-1:0] LAST_X = X_W'(HEAP_BYTES - NODE_BYTES);

  localparam logic [SZ_W-1:0] FREE_INIT =
    HAS_BLOCK ? SZ_W'(HEAP_BYTES - ROOT_BYTES - NODE_BYTES) : '0;
  localparam logic [SZ_W:0] ROOT_ENT = {HAS_BLOCK, FREE_INIT};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_SPLIT = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic            root_init_r;
  logic [SZ_W-1:0] fbc_r, fbc_nxt;
  logic [WA_W-1:0] addr_r, addr_nxt;
  logic [X_W-1:0]  size_r, size_nxt;
  logic [WA_W-1:0] rest_addr_r, rest_addr_nxt;
  logic [SZ_W-1:0] rest_size_r, rest_size_nxt;
  ffha_rsp_t       res_r, res_nxt;

  logic [WA_W-1:0] wr_addr_w;
  logic [SZ_W:0]   ent;
  logic            ent_free;
  logic [X_W-1:0]  hsize_x;
  logic [X_W-1:0]  addr_x;
  logic [X_W-1:0]  in_size_x;
  logic [X_W-1:0]  off_x;
  logic [X_W-1:0]  rel_x;
  logic [X_W-1:0]  fbc_x;
  logic [X_W-1:0]  charge_x;
  logic [X_W-1:0]  dec_x;
  logic [X_W-1:0]  left_x;
  logic [X_W-1:0]  rest_x;
  logic [X_W-1:0]  next_x;
  logic [X_W-1:0]  sum_x;
  logic [X_W-1:0]  pay_x;
  logic [X_W-1:0]  rem_x;
  logic            found;
  logic            split;

  function automatic logic [FREE_W-1:0] free_out(input logic [SZ_W-1:0] v);
    logic [X_W-1:0] w;
    w = X_W'(v);
    return w[FREE_W-1:0];
  endfunction

  // the root header keeps its reset value until first written
  assign ent      = (root_init_r && (X_W'(addr_r) == ROOT_X)) ? ROOT_ENT : mem_rd_data;
  assign ent_free = ent[SZ_W];
  assign hsize_x  = X_W'(ent[SZ_W-1:0]);
  assign addr_x   = X_W'(addr_r);
  assign fbc_x    = X_W'(fbc_r);

  assign in_size_x = X_W'(req.request_size);
  assign off_x     = X_W'(req.block_offset);
  assign rel_x     = off_x - NODE_X;

  assign found    = ent_free && (hsize_x >= size_r);
  assign left_x   = hsize_x - size_r;
  assign rest_x   = addr_x + NODE_X + size_r;
  assign split    = (left_x > NODE_X) && (rest_x < HEAP_X);
  assign rem_x    = left_x - NODE_X;
  assign next_x   = addr_x + NODE_X + hsize_x;
  assign charge_x = size_r + NODE_X;
  assign dec_x    = fbc_x - charge_x;
  assign sum_x    = fbc_x + hsize_x;
  assign pay_x    = addr_x + NODE_X;

  assign busy        = (state_r != S_IDLE);
  assign res_valid   = (state_r == S_RESP);
  assign res         = res_r;
  assign mem_wr_addr = wr_addr_w[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    fbc_nxt       = fbc_r;
    addr_nxt      = addr_r;
    size_nxt      = size_r;
    rest_addr_nxt = rest_addr_r;
    rest_size_nxt = rest_size_r;
    res_nxt       = res_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = addr_r[AW-1:0];
    mem_wr_en     = 1'b0;
    wr_addr_w     = addr_r;
    mem_wr_data   = ent;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          if (req.opcode == OP_ALLOC) begin
            size_nxt = in_size_x;
            if (in_size_x >= fbc_x || !HAS_BLOCK) begin
              res_nxt   = '{status: ST_FAIL, payload_offset: '0, free_bytes: free_out(fbc_r)};
              state_nxt = S_RESP;
            end else begin
              addr_nxt    = ROOT_X[WA_W-1:0];
              mem_rd_en   = 1'b1;
              mem_rd_addr = ROOT_X[AW-1:0];
              state_nxt   = S_WALK;
            end
          end else begin
            res_nxt = '{status: ST_FAIL, payload_offset: req.block_offset,
                        free_bytes: free_out(fbc_r)};
            if (off_x < NODE_X || rel_x >= HEAP_X) begin
              state_nxt = S_RESP;
            end else begin
              addr_nxt    = rel_x[WA_W-1:0];
              mem_rd_en   = 1'b1;
              mem_rd_addr = rel_x[AW-1:0];
              state_nxt   = S_REL;
            end
          end
        end
      end

      S_WALK: begin
        if (found) begin
          fbc_nxt     = (fbc_x > charge_x) ? dec_x[SZ_W-1:0] : '0;
          mem_wr_en   = 1'b1;
          wr_addr_w   = addr_r;
          mem_wr_data = {1'b0, split ? size_r[SZ_W-1:0] : ent[SZ_W-1:0]};
          res_nxt     = '{status: ST_OK, payload_offset: pay_x[OFF_W-1:0],
                          free_bytes: free_out(fbc_nxt)};
          rest_addr_nxt = rest_x[WA_W-1:0];
          rest_size_nxt = rem_x[SZ_W-1:0];
          state_nxt     = split ? S_SPLIT : S_RESP;
        end else if (next_x <= LAST_X) begin
          addr_nxt    = next_x[WA_W-1:0];
          mem_rd_en   = 1'b1;
          mem_rd_addr = next_x[AW-1:0];
        end else begin
          res_nxt   = '{status: ST_FAIL, payload_offset: '0, free_bytes: free_out(fbc_r)};
          state_nxt = S_RESP;
        end
      end

      S_SPLIT: begin
        // free remainder header behind the new payload
        mem_wr_en   = 1'b1;
        wr_addr_w   = rest_addr_r;
        mem_wr_data = {1'b1, rest_size_r};
        state_nxt   = S_RESP;
      end

      S_REL: begin
        fbc_nxt     = (sum_x > HEAP_X) ? HEAP_X[SZ_W-1:0] : sum_x[SZ_W-1:0];
        mem_wr_en   = 1'b1;
        wr_addr_w   = addr_r;
        mem_wr_data = {1'b1, ent[SZ_W-1:0]};
        res_nxt.status     = ST_OK;
        res_nxt.free_bytes = free_out(fbc_nxt);
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fbc_r       <= FREE_INIT;
      root_init_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      fbc_r   <= fbc_nxt;
      if (mem_wr_en && (X_W'(wr_addr_w) == ROOT_X)) begin
        root_init_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    size_r      <= size_nxt;
    rest_addr_r <= rest_addr_nxt;
    rest_size_r <= rest_size_nxt;
    res_r       <= res_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the allocator's request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_checker #(
  parameter int HEAP_BYTES = 1024
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire ffha_pkg::ffha_req_t in_req,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ffha_pkg::ffha_rsp_t out_rsp
);

  import ffha_pkg::*;

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled response changed");

  // one request in flight: a taken request blocks the next
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in progress");

  // free-byte count never above the heap size
  a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_rsp.free_bytes) <= HEAP_BYTES))
    else $error("free-byte count above heap size");

  // a failed allocate never reports a payload
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_rsp.status == ST_FAIL && $past(in_req.opcode, 2) == OP_ALLOC
      && $past(in_valid && !in_stall, 2)
    |-> out_rsp.payload_offset == '0)
    else $error("refused allocate with non-zero offset");

endmodule

bind first_fit_heap_allocator ffha_checker #(
  .HEAP_BYTES (HEAP_BYTES)
) u_ffha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);

`default_nettype wire

// ----- verif/ffha_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_tb_checker
// Watches both channels of the first-fit heap allocator, keeps its own copy
// of the header chain and free-byte count, predicts the response to every
// accepted request and compares each accepted response field by field.
// ----------------------------------------------------------------------------

module ffha_tb_checker #(
  parameter int HEAP_BYTES = 1024,
  parameter int NODE_BYTES = 16,
  parameter int ROOT_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ffha_pkg::ffha_req_t in_req,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ffha_pkg::ffha_rsp_t out_rsp,
  output int                  mismatches,
  output int                  outstanding
);

  import ffha_pkg::*;

  logic [11:0]       hdr_size [HEAP_BYTES];
  logic              hdr_free [HEAP_BYTES];
  logic [FREE_W-1:0] free_count;
  ffha_rsp_t         pending_rsp_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // applies one request to the shadow heap and returns the response it causes
  function automatic ffha_rsp_t apply_heap_request(ffha_req_t r);
    ffha_rsp_t rsp;
    int        sz;
    int        fc;
    int        a;
    int        steps;
    int        leftover;
    int        rest;
    int        off;
    int        sum;
    bit        found;
    rsp = '0;
    fc  = int'(free_count);
    if (r.opcode == OP_ALLOC) begin
      sz = int'(r.request_size);
      rsp.status = ST_FAIL;
      rsp.payload_offset = '0;
      if (sz < fc) begin
        a = ROOT_BYTES;
        found = 1'b0;
        for (steps = 0; steps < HEAP_BYTES && a + NODE_BYTES <= HEAP_BYTES && !found;
             steps++) begin
          if (hdr_free[a] && int'(hdr_size[a]) >= sz) found = 1'b1;
          else a = a + NODE_BYTES + int'(hdr_size[a]);
        end
        if (found) begin
          fc = (fc > sz + NODE_BYTES) ? fc - (sz + NODE_BYTES) : 0;
          free_count = FREE_W'(fc);
          hdr_free[a] = 1'b0;
          leftover = int'(hdr_size[a]) - sz;
          // split off the tail as a new free block when it is larger than a header and starts inside the heap
          if (leftover > NODE_BYTES) begin
            rest = a + NODE_BYTES + sz;
            if (rest < HEAP_BYTES) begin
              hdr_size[rest] = 12'(leftover - NODE_BYTES);
              hdr_free[rest] = 1'b1;
              hdr_size[a]    = 12'(sz);
            end
          end
          rsp.status = ST_OK;
          rsp.payload_offset = OFF_W'(a + NODE_BYTES);
        end
      end
    end else begin
      off = int'(r.block_offset);
      rsp.payload_offset = r.block_offset;
      if (off < NODE_BYTES || off - NODE_BYTES >= HEAP_BYTES) begin
        rsp.status = ST_FAIL;
      end else begin
        a = off - NODE_BYTES;
        hdr_free[a] = 1'b1;
        sum = fc + int'(hdr_size[a]);
        free_count = FREE_W'((sum > HEAP_BYTES) ? HEAP_BYTES : sum);
        rsp.status = ST_OK;
      end
    end
    rsp.free_bytes = free_count;
    return rsp;
  endfunction

  always @(posedge clk) begin
    ffha_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < HEAP_BYTES; i++) begin
        hdr_size[i] = '0;
        hdr_free[i] = 1'b0;
      end
      if (ROOT_BYTES + NODE_BYTES <= HEAP_BYTES) begin
        free_count = FREE_W'(HEAP_BYTES - ROOT_BYTES - NODE_BYTES);
        hdr_size[ROOT_BYTES] = 12'(HEAP_BYTES - ROOT_BYTES - NODE_BYTES);
        hdr_free[ROOT_BYTES] = 1'b1;
      end else begin
        free_count = '0;
      end
      pending_rsp_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with no request waiting: status %0d offset %0d free %0d",
                 out_rsp.status, out_rsp.payload_offset, out_rsp.free_bytes);
          mismatches++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp.status);
            mismatches++;
          end
          if (out_rsp.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   want.payload_offset, out_rsp.payload_offset);
            mismatches++;
          end
          if (out_rsp.free_bytes !== want.free_bytes) begin
            $error("free_bytes: expected %0d, got %0d", want.free_bytes, out_rsp.free_bytes);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) pending_rsp_q.push_back(apply_heap_request(in_req));
    end
    outstanding = pending_rsp_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and release requests into the first-fit heap allocator
// under several idling patterns and back-pressure, and reports the verdict
// from the checker sitting beside the block.
// ----------------------------------------------------------------------------

module testbench;

  import ffha_pkg::*;

  localparam int HEAP_BYTES = 1024;
  localparam int NODE_BYTES = 16;
  localparam int ROOT_BYTES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 112;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ffha_req_t in_req = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ffha_rsp_t out_rsp;

  int mismatches;
  int outstanding;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // payload offsets known to have a written header in front of them
  bit           known_block [HEAP_BYTES];
  logic [OFF_W-1:0] block_pool_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_heap_allocator #(
    .HEAP_BYTES(HEAP_BYTES),
    .NODE_BYTES(NODE_BYTES),
    .ROOT_BYTES(ROOT_BYTES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  ffha_tb_checker #(
    .HEAP_BYTES(HEAP_BYTES),
    .NODE_BYTES(NODE_BYTES),
    .ROOT_BYTES(ROOT_BYTES)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // receiver: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // every successful response names a block whose header has been written
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_rsp.status == ST_OK &&
        !known_block[out_rsp.payload_offset]) begin
      known_block[out_rsp.payload_offset] = 1'b1;
      block_pool_q.push_back(out_rsp.payload_offset);
    end
  end

  function automatic ffha_req_t mk_alloc(int sz);
    ffha_req_t r;
    r.opcode = OP_ALLOC;
    r.request_size = SIZE_W'(sz);
    r.block_offset = OFF_W'($urandom_range(0, HEAP_BYTES - 1));
    return r;
  endfunction

  function automatic ffha_req_t mk_release(int off);
    ffha_req_t r;
    r.opcode = OP_RELEASE;
    r.request_size = SIZE_W'($urandom_range(0, HEAP_BYTES));
    r.block_offset = OFF_W'(off);
    return r;
  endfunction

  function automatic ffha_req_t next_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 52) begin
      if ($urandom_range(0, 9) < 8) return mk_alloc($urandom_range(0, 48));
      return mk_alloc($urandom_range(0, HEAP_BYTES));
    end else if (roll < 93) begin
      if (block_pool_q.size() == 0) return mk_release(ROOT_BYTES + NODE_BYTES);
      return mk_release(block_pool_q[$urandom_range(0, block_pool_q.size() - 1)]);
    end
    // offsets inside the root area are refused
    return mk_release($urandom_range(0, NODE_BYTES - 1));
  endfunction

  task automatic send(ffha_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle  = '{0, 83, 0, 16};
    phase_stall = '{0, 0, 83, 16};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: refusals, whole-heap grab, double release, splits, exact fits
    send(mk_alloc(HEAP_BYTES));
    send(mk_alloc(HEAP_BYTES - ROOT_BYTES - NODE_BYTES));
    send(mk_alloc(HEAP_BYTES - ROOT_BYTES - NODE_BYTES - 1));
    send(mk_alloc(0));
    send(mk_release(ROOT_BYTES + NODE_BYTES));
    send(mk_release(ROOT_BYTES + NODE_BYTES));
    send(mk_alloc(1000));
    send(mk_release(0));
    send(mk_release(NODE_BYTES - 1));
    send(mk_alloc(0));
    send(mk_alloc(17));
    send(mk_alloc(942));
    send(mk_release(48));
    send(mk_alloc(17));
    send(mk_release(32));
    send(mk_alloc(0));
    send(mk_release(81));
    send(mk_alloc(1));
    send(mk_alloc(NODE_BYTES));
    send(mk_alloc(NODE_BYTES + 1));
    send(mk_release(48));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 0 && n == 30) hold_seq++;
        send(next_request());
      end
      wait_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
